[hdl/rgbbox_pkg.sv]
package rgbbox_pkg;

    localparam int CFG_W        = 12;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;
    localparam int CHAN_W       = 8;
    localparam int SHIFT_W      = 6;
    localparam int PAIR_W       = 7;

    localparam int MAX_WIDTH_DEFAULT  = 2048;
    localparam int MAX_HEIGHT_DEFAULT = 2048;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    // Largest value a block sum can take: four times 63
    localparam logic [CHAN_W-1:0] BLOCK_MAX = 8'd252;

    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] red_in;
    } pixel_t;

    typedef struct packed
    {
        logic              frame_done;
        logic [CHAN_W-1:0] blue_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] red_out;
    } block_t;

    // Pixel with each channel shifted right by two
    typedef struct packed
    {
        logic [SHIFT_W-1:0] blue;
        logic [SHIFT_W-1:0] green;
        logic [SHIFT_W-1:0] red;
    } quarter_t;

    // Horizontal pair sum, also the line buffer entry
    typedef struct packed
    {
        logic [PAIR_W-1:0] blue;
        logic [PAIR_W-1:0] green;
        logic [PAIR_W-1:0] red;
    } pair_t;

    localparam int PAIR_BITS = $bits(pair_t);

endpackage

[hdl/rgbbox_ram.sv]
module rgbbox_ram
#(
    parameter int WIDTH = 21,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/rgb_2x2_box_downsample_core.sv]
// Channel   Direction  Handshake                    Word
// pixel     in         pixel_valid / pixel_ready    rgbbox_pkg::pixel_t, raster order
// block     out        block_valid / block_ready    rgbbox_pkg::block_t, one per 2x2 block
// config    in         APB psel/penable/pwrite      image_width @0x0, image_height @0x4
//
// One pixel per cycle while the block side does not stall. A block word follows its
// lower-right pixel through the line buffer read register, then the output register.
// Reset clears the counters, the left-pixel hold and the pipeline valids; sizes reset
// to 640 x 480. The line buffer is not cleared; upper-row entries are written before use.
// A stall on the block side holds the output register, then the stage behind it, then
// pixel_ready drops.
module rgb_2x2_box_downsample_core
#(
    parameter int MAX_WIDTH  = rgbbox_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = rgbbox_pkg::MAX_HEIGHT_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              pixel_valid,
    output logic                              pixel_ready,
    input  rgbbox_pkg::pixel_t                pixel,

    output logic                              block_valid,
    input  logic                              block_ready,
    output rgbbox_pkg::block_t                block,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rgbbox_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rgbbox_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rgbbox_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int EW    = $clog2(MAX_WIDTH + 1);
    localparam int EH    = $clog2(MAX_HEIGHT + 1);
    localparam int AW    = CW - 1;
    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int CFG_W = rgbbox_pkg::CFG_W;

    // Configuration
    logic [CFG_W-1:0] width_reg,  width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic             cfg_write;
    rgbbox_pkg::reg_idx_t cfg_sel;

    // Position and hold
    logic [CW-1:0]         col_reg,  col_next;
    logic [RW-1:0]         row_reg,  row_next;
    rgbbox_pkg::quarter_t  hold_reg, hold_next;

    // Pipeline
    logic                  s1_valid_reg,  s1_valid_next;
    rgbbox_pkg::pair_t     s1_pair_reg;
    logic                  s1_last_reg;
    logic                  out_valid_reg, out_valid_next;
    rgbbox_pkg::block_t    out_reg;

    logic [EW-1:0]         w_eff;
    logic [EH-1:0]         h_eff;
    logic [EW-1:0]         last_col;
    logic [EH-1:0]         last_row;
    logic [CW:0]           col_inc;
    logic [RW:0]           row_inc;
    rgbbox_pkg::quarter_t  quarter;
    rgbbox_pkg::pair_t     pair;
    rgbbox_pkg::pair_t     upper;
    logic                  accept;
    logic                  in_block;
    logic                  is_last;
    logic                  ram_we;
    logic                  ram_re;
    logic                  s1_adv;
    logic [rgbbox_pkg::PAIR_BITS-1:0] ram_rdata;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = rgbbox_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        prdata      = '0;
        unique case (cfg_sel)
            rgbbox_pkg::REG_IMAGE_WIDTH:
            begin
                prdata = rgbbox_pkg::APB_DATA_W'(width_reg);
                if (cfg_write)
                begin
                    width_next = pwdata[CFG_W-1:0];
                end
            end
            rgbbox_pkg::REG_IMAGE_HEIGHT:
            begin
                prdata = rgbbox_pkg::APB_DATA_W'(height_reg);
                if (cfg_write)
                begin
                    height_next = pwdata[CFG_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // ---------------- stage 0: position, pair sum, line buffer access ----------------
    assign w_eff = (32'(width_reg) < 32'(MAX_WIDTH))  ? EW'(width_reg)  : EW'(MAX_WIDTH);
    assign h_eff = (32'(height_reg) < 32'(MAX_HEIGHT)) ? EH'(height_reg) : EH'(MAX_HEIGHT);

    // Odd last column or row is dropped
    assign last_col = {w_eff[EW-1:1], 1'b0} - EW'(1);
    assign last_row = {h_eff[EH-1:1], 1'b0} - EH'(1);

    assign quarter.red   = pixel.red_in[7:2];
    assign quarter.green = pixel.green_in[7:2];
    assign quarter.blue  = pixel.blue_in[7:2];

    assign pair.red   = 7'(hold_reg.red)   + 7'(quarter.red);
    assign pair.green = 7'(hold_reg.green) + 7'(quarter.green);
    assign pair.blue  = 7'(hold_reg.blue)  + 7'(quarter.blue);

    assign accept   = pixel_valid && pixel_ready;
    assign in_block = (32'(col_reg) < 32'(w_eff)) && (32'(row_reg) < 32'(h_eff));
    assign is_last  = (32'(col_reg) == 32'(last_col)) && (32'(row_reg) == 32'(last_row));
    assign ram_we   = accept && in_block && col_reg[0] && !row_reg[0];
    assign ram_re   = accept && in_block && col_reg[0] && row_reg[0];

    assign col_inc = {1'b0, col_reg} + (CW + 1)'(1);
    assign row_inc = {1'b0, row_reg} + (RW + 1)'(1);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        hold_next = hold_reg;
        if (accept)
        begin
            if (in_block && !col_reg[0])
            begin
                hold_next = quarter;
            end
            // Wrap column into next row; a row beyond the height wraps to zero
            if (32'(col_inc) >= 32'(w_eff))
            begin
                col_next = '0;
                row_next = (32'(row_inc) >= 32'(h_eff)) ? '0 : row_inc[RW-1:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
                row_next = (32'(row_reg) >= 32'(h_eff)) ? '0 : row_reg;
            end
        end
    end

    rgbbox_ram
    #(
        .WIDTH (rgbbox_pkg::PAIR_BITS),
        .DEPTH (DEPTH)
    )
    u_line_buf
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg[CW-1:1]),
        .wdata (pair),
        .re    (ram_re),
        .raddr (col_reg[AW:1]),
        .rdata (ram_rdata)
    );

    // ---------------- stage 1 and output register ----------------
    assign s1_adv      = !out_valid_reg || block_ready;
    assign pixel_ready = !s1_valid_reg || s1_adv;
    assign upper       = rgbbox_pkg::pair_t'(ram_rdata);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (ram_re)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_valid_reg && s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (block_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= rgbbox_pkg::WIDTH_RESET;
            height_reg    <= rgbbox_pkg::HEIGHT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            hold_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            hold_reg      <= hold_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: load on advance, hold while stalled
    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            s1_pair_reg <= pair;
            s1_last_reg <= is_last;
        end
        if (s1_valid_reg && s1_adv)
        begin
            out_reg.red_out    <= 8'(upper.red)   + 8'(s1_pair_reg.red);
            out_reg.green_out  <= 8'(upper.green) + 8'(s1_pair_reg.green);
            out_reg.blue_out   <= 8'(upper.blue)  + 8'(s1_pair_reg.blue);
            out_reg.frame_done <= s1_last_reg;
        end
    end

    assign block_valid = out_valid_reg;
    assign block       = out_reg;

endmodule

[hdl/rgbbox_checker.sv]
module rgbbox_core_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pixel_ready,
    input  logic                              block_valid,
    input  logic                              block_ready,
    input  rgbbox_pkg::block_t                block,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rgbbox_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rgbbox_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [rgbbox_pkg::APB_DATA_W-1:0] prdata,
    input  logic                              pready
);

    // A stalled block word holds
    a_block_hold: assert property (@(posedge clk) disable iff (!rst_n)
        block_valid && !block_ready |=> block_valid && $stable(block))
        else $error("block word changed while stalled");

    // Each channel is a sum of four 6-bit values
    a_block_range: assert property (@(posedge clk) disable iff (!rst_n)
        block_valid |-> (block.red_out <= rgbbox_pkg::BLOCK_MAX)
                     && (block.green_out <= rgbbox_pkg::BLOCK_MAX)
                     && (block.blue_out <= rgbbox_pkg::BLOCK_MAX))
        else $error("block channel above four-pixel maximum");

    // With the output side empty or draining, the pipeline never back-pressures pixels
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!block_valid || block_ready) |-> pixel_ready)
        else $error("pixel_ready low while output side is free");

    // A written size reads back at the same address next cycle
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready |=>
            ($stable(paddr) |-> prdata[rgbbox_pkg::CFG_W-1:0]
                                 == $past(pwdata[rgbbox_pkg::CFG_W-1:0])))
        else $error("configuration register readback mismatch");

endmodule

bind rgb_2x2_box_downsample_core rgbbox_core_checker u_rgbbox_checker (.*);

[tb/rgbbox_checker.sv]
`timescale 1ns / 1ps

module rgbbox_checker
#(
    parameter int MAX_WIDTH  = rgbbox_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = rgbbox_pkg::MAX_HEIGHT_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              pixel_valid,
    input  logic                              pixel_ready,
    input  rgbbox_pkg::pixel_t                pixel,

    input  logic                              block_valid,
    input  logic                              block_ready,
    input  rgbbox_pkg::block_t                block,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rgbbox_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rgbbox_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                              pready,

    output int                                block_errors,
    output int                                blocks_due
);

    logic [rgbbox_pkg::CFG_W-1:0] width_q  = rgbbox_pkg::WIDTH_RESET;
    logic [rgbbox_pkg::CFG_W-1:0] height_q = rgbbox_pkg::HEIGHT_RESET;
    logic [10:0]                  col_q    = '0;
    logic [10:0]                  row_q    = '0;
    rgbbox_pkg::quarter_t         left_hold = '0;
    rgbbox_pkg::pair_t            upper_row [0:MAX_WIDTH/2-1];
    rgbbox_pkg::block_t           pending_blocks [$];
    int                           err_count = 0;

    // Advance the raster position by one pixel; queue a block word when
    // the pixel closes a 2x2 block.
    task automatic fold_pixel(input rgbbox_pkg::pixel_t px);
        int unsigned          w_eff;
        int unsigned          h_eff;
        int unsigned          c;
        int unsigned          r;
        int unsigned          idx;
        rgbbox_pkg::quarter_t q;
        rgbbox_pkg::pair_t    hsum;
        rgbbox_pkg::pair_t    up;
        rgbbox_pkg::block_t   want;
        w_eff = (width_q < MAX_WIDTH) ? width_q : MAX_WIDTH;
        h_eff = (height_q < MAX_HEIGHT) ? height_q : MAX_HEIGHT;
        c = col_q;
        r = row_q;
        q.red   = px.red_in[7:2];
        q.green = px.green_in[7:2];
        q.blue  = px.blue_in[7:2];
        if (c < w_eff && r < h_eff)
        begin
            if (c[0] == 1'b0)
            begin
                left_hold = q;
            end
            else
            begin
                idx = (c >> 1) & (MAX_WIDTH/2 - 1);
                hsum.red   = left_hold.red   + q.red;
                hsum.green = left_hold.green + q.green;
                hsum.blue  = left_hold.blue  + q.blue;
                if (r[0] == 1'b0)
                begin
                    upper_row[idx] = hsum;
                end
                else
                begin
                    up = upper_row[idx];
                    want.red_out    = up.red   + hsum.red;
                    want.green_out  = up.green + hsum.green;
                    want.blue_out   = up.blue  + hsum.blue;
                    want.frame_done = (c == (w_eff & 32'hFFFF_FFFE) - 1)
                                   && (r == (h_eff & 32'hFFFF_FFFE) - 1);
                    pending_blocks.push_back(want);
                end
            end
        end
        // Column wrap advances the row; a row past the size wraps either way
        c++;
        if (c >= w_eff)
        begin
            c = 0;
            r++;
            if (r >= h_eff)
            begin
                r = 0;
            end
        end
        else if (r >= h_eff)
        begin
            r = 0;
        end
        col_q = c[10:0];
        row_q = r[10:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rgbbox_pkg::block_t want;
        if (!rst_n)
        begin
            width_q   = rgbbox_pkg::WIDTH_RESET;
            height_q  = rgbbox_pkg::HEIGHT_RESET;
            col_q     = '0;
            row_q     = '0;
            left_hold = '0;
            pending_blocks.delete();
            blocks_due <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                unique case (rgbbox_pkg::reg_idx_t'(paddr[2]))
                    rgbbox_pkg::REG_IMAGE_WIDTH:  width_q  = pwdata[rgbbox_pkg::CFG_W-1:0];
                    rgbbox_pkg::REG_IMAGE_HEIGHT: height_q = pwdata[rgbbox_pkg::CFG_W-1:0];
                    default: ;
                endcase
            end

            if (pixel_valid && pixel_ready)
                fold_pixel(pixel);

            if (block_valid && block_ready)
            begin
                if (pending_blocks.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: unexpected block word r=%0d g=%0d b=%0d done=%0b",
                                 $realtime, block.red_out, block.green_out, block.blue_out,
                                 block.frame_done);
                end
                else
                begin
                    want = pending_blocks.pop_front();
                    if (block.red_out !== want.red_out || block.green_out !== want.green_out
                        || block.blue_out !== want.blue_out
                        || block.frame_done !== want.frame_done)
                    begin
                        err_count++;
                        if (err_count <= 10)
                        begin
                            $display("%0t: block mismatch", $realtime);
                            $display("    expected r=%0d g=%0d b=%0d done=%0b",
                                     want.red_out, want.green_out, want.blue_out,
                                     want.frame_done);
                            $display("    actual   r=%0d g=%0d b=%0d done=%0b",
                                     block.red_out, block.green_out, block.blue_out,
                                     block.frame_done);
                        end
                    end
                end
            end

            blocks_due <= pending_blocks.size();
        end
        block_errors <= err_count;
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int PIPE_SETTLE  = 8;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 270;

    localparam rgbbox_pkg::pixel_t EDGE_PATTERN [0:7] = '{
        24'h0300FF, 24'hFCFF00, 24'hFFFC03, 24'h0003FC,
        24'h7F8055, 24'hAA557F, 24'h55AA80, 24'h807FAA
    };

    logic                              clk;
    logic                              rst_n       = 1'b0;
    logic                              pixel_valid = 1'b0;
    logic                              pixel_ready;
    rgbbox_pkg::pixel_t                pixel       = '0;
    logic                              block_valid;
    logic                              block_ready = 1'b0;
    rgbbox_pkg::block_t                block;
    logic                              psel        = 1'b0;
    logic                              penable     = 1'b0;
    logic                              pwrite      = 1'b0;
    logic [rgbbox_pkg::APB_ADDR_W-1:0] paddr       = '0;
    logic [rgbbox_pkg::APB_DATA_W-1:0] pwdata      = '0;
    logic [rgbbox_pkg::APB_DATA_W-1:0] prdata;
    logic                              pready;
    logic                              hold_req    = 1'b0;

    int block_errors;
    int blocks_due;
    int burst_left = 0;

    rgb_2x2_box_downsample_core DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .block_valid (block_valid),
        .block_ready (block_ready),
        .block       (block),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    rgbbox_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .block_valid  (block_valid),
        .block_ready  (block_ready),
        .block        (block),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .block_errors (block_errors),
        .blocks_due   (blocks_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(4_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [7:0] rand_chan();
        unique case ($urandom_range(0, 11))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h03;
            3:       return 8'hFC;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic rgbbox_pkg::pixel_t rand_pixel();
        rgbbox_pkg::pixel_t px;
        px.red_in   = rand_chan();
        px.green_in = rand_chan();
        px.blue_in  = rand_chan();
        return px;
    endfunction

    // Pixels that bring the raster counters back to the frame origin
    function automatic int frame_pixels(input int w, input int h);
        int w_eff;
        int h_eff;
        w_eff = (w > rgbbox_pkg::MAX_WIDTH_DEFAULT) ? rgbbox_pkg::MAX_WIDTH_DEFAULT : w;
        h_eff = (h > rgbbox_pkg::MAX_HEIGHT_DEFAULT) ? rgbbox_pkg::MAX_HEIGHT_DEFAULT : h;
        return ((w_eff == 0) ? 1 : w_eff) * ((h_eff == 0) ? 1 : h_eff);
    endfunction

    task automatic cfg_write(input rgbbox_pkg::reg_idx_t idx,
                             input logic [rgbbox_pkg::CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= rgbbox_pkg::APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_geometry(input int w, input int h);
        cfg_write(rgbbox_pkg::REG_IMAGE_WIDTH, w[rgbbox_pkg::CFG_W-1:0]);
        cfg_write(rgbbox_pkg::REG_IMAGE_HEIGHT, h[rgbbox_pkg::CFG_W-1:0]);
    endtask

    // Present one word; bursts of random length separated by random gaps
    task automatic push_pixel(input rgbbox_pkg::pixel_t px);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                pixel_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_random(input int n);
        repeat (n) push_pixel(rand_pixel());
    endtask

    // Drop valid and hold until every expected word is back and the pipe is empty
    task automatic settle();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (blocks_due != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    task automatic run_phase(input int w, input int h, input int n_frames);
        set_geometry(w, h);
        send_random(frame_pixels(w, h) * n_frames);
        settle();
    endtask

    function automatic int pick_size(input int even_max, input int odd_max);
        unique case ($urandom_range(0, 15))
            0:       return $urandom_range(0, 1);
            1, 2, 3: return 2 * $urandom_range(1, odd_max / 2) + 1;
            default: return 2 * $urandom_range(1, even_max / 2);
        endcase
    endfunction

    // Receiver: random stall patterns, plus one long hold-off on request
    initial
    begin
        int mode;
        int span;
        bit held;
        mode = 0;
        span = 0;
        held = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                block_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 80);
            end
            span--;
            unique case (mode)
                0:       block_ready <= 1'b1;
                1:       block_ready <= ($urandom_range(0, 1) == 1);
                2:       block_ready <= ($urandom_range(0, 7) == 0);
                default: block_ready <= ~block_ready;
            endcase
        end
    end

    initial
    begin
        int w;
        int h;
        int n;
        int random_items;
        random_items = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Channel extremes: saturated and empty blocks
        set_geometry(2, 2);
        repeat (4) push_pixel(24'hFFFFFF);
        settle();
        set_geometry(2, 2);
        repeat (4) push_pixel(24'h000000);
        settle();

        // Mixed per-channel values, two blocks in one row pair
        set_geometry(4, 2);
        for (int i = 0; i < 8; i++)
            push_pixel(EDGE_PATTERN[i]);
        settle();

        // Odd size: last column and last row drop out
        run_phase(3, 3, 1);

        // Sizes that hold no complete block
        run_phase(0, 4, 1);
        run_phase(1, 1, 1);
        run_phase(5, 0, 1);
        run_phase(1, 6, 1);

        // Height shrinks while the row counter sits past the new last row
        run_phase(8, 4, 1);
        set_geometry(8, 6);
        send_random(24);
        settle();
        cfg_write(rgbbox_pkg::REG_IMAGE_HEIGHT, 12'd2);
        send_random(16);
        settle();

        // Width shrinks in the middle of a row
        set_geometry(8, 4);
        send_random(4);
        settle();
        cfg_write(rgbbox_pkg::REG_IMAGE_WIDTH, 12'd4);
        send_random(13);
        settle();

        // Receiver holds off while words keep coming, so the input stalls
        hold_req <= 1'b1;
        run_phase(16, 8, 1);

        // Random frames
        while (random_items < RANDOM_ITEMS)
        begin
            w = pick_size(16, 15);
            h = pick_size(10, 9);
            n = $urandom_range(1, 2);
            run_phase(w, h, n);
            random_items += frame_pixels(w, h) * n;
        end

        settle();
        if (block_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
hdl/rgbbox_pkg.sv
hdl/rgbbox_ram.sv
hdl/rgb_2x2_box_downsample_core.sv
hdl/rgbbox_checker.sv
tb/rgbbox_checker.sv
tb/tb_top.sv
